// ----- rtl/core/sm3_pkg.sv -----
// sm3 hash engine shared types, constants and word functions
package sm3_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;

    localparam t_word T_LOW       = 32'h79cc4519;
    localparam t_word T_HIGH      = 32'h7a879d8a;
    // round constant of the upper rounds already rotated for round 16
    localparam t_word T_HIGH_R16  = {T_HIGH[15:0], T_HIGH[31:16]};
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam t_word PAD_WORD    = {PAD_BYTE, 24'h000000};

    localparam t_word IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } t_state;

    // controls from the sequencer to the round unit
    typedef struct packed {
        logic load;     // copy chaining value into working registers
        logic step;     // run one round
        logic fold;     // last round: xor result into chaining value
        logic restore;  // back to the initial value
        logic early;    // rounds 0 to 15
        logic t_jump;   // round 15: switch round constant
    } t_rnd_ctl;

    // rotate left by a constant amount of 1 to 31
    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word perm0(input t_word x);
        perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic t_word perm1(input t_word x);
        perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    // keep the leading bytes of a short final word and append the pad byte
    function automatic t_word pad_word(input t_word data, input logic [1:0] nb);
        case (nb)
            2'd0:    pad_word = PAD_WORD;
            2'd1:    pad_word = {data[31:24], PAD_BYTE, 16'h0000};
            2'd2:    pad_word = {data[31:16], PAD_BYTE, 8'h00};
            default: pad_word = {data[31:8], PAD_BYTE};
        endcase
    endfunction

endpackage

// ----- rtl/core/sm3_msg_sched.sv -----
// sm3 block buffer that doubles as the sliding message expansion window
module sm3_msg_sched (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [3:0]          i_wr_pos,
    input  sm3_pkg::t_word      i_wr_data,
    input  logic                i_shift,
    output sm3_pkg::t_word      o_w_j,
    output sm3_pkg::t_word      o_w_j4
);

    sm3_pkg::t_word r_buf [sm3_pkg::BLOCK_WORDS];
    sm3_pkg::t_word w_new;

    // next expanded word from the current window
    always_comb begin
        w_new = sm3_pkg::perm1(r_buf[0] ^ r_buf[7] ^ sm3_pkg::rotl(r_buf[13], 15))
                ^ sm3_pkg::rotl(r_buf[3], 7) ^ r_buf[10];
    end

    // word store while absorbing, window shift while compressing
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < sm3_pkg::BLOCK_WORDS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[sm3_pkg::BLOCK_WORDS-1] <= w_new;
        end else if (i_wr_en) begin
            r_buf[i_wr_pos] <= i_wr_data;
        end
    end

    assign o_w_j  = r_buf[0];
    assign o_w_j4 = r_buf[4];

endmodule

// ----- rtl/core/sm3_round.sv -----
// sm3 compression round unit, one round per cycle, with chaining value
module sm3_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sm3_pkg::t_rnd_ctl   i_ctl,
    input  sm3_pkg::t_word      i_w_j,
    input  sm3_pkg::t_word      i_w_j4,
    output sm3_pkg::t_word      o_cv [8]
);

    sm3_pkg::t_word r_cv [8];
    sm3_pkg::t_word r_v  [8];
    sm3_pkg::t_word n_v  [8];
    sm3_pkg::t_word r_t;
    sm3_pkg::t_word a12, ss1, ss2, ff, gg, tt1, tt2;

    // one round of the compression function
    always_comb begin
        a12 = sm3_pkg::rotl(r_v[0], 12);
        ss1 = sm3_pkg::rotl(a12 + r_v[4] + r_t, 7);
        ss2 = ss1 ^ a12;
        if (i_ctl.early) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + (i_w_j ^ i_w_j4);
        tt2 = gg + r_v[7] + ss1 + i_w_j;
        n_v[0] = tt1;
        n_v[1] = r_v[0];
        n_v[2] = sm3_pkg::rotl(r_v[1], 9);
        n_v[3] = r_v[2];
        n_v[4] = sm3_pkg::perm0(tt2);
        n_v[5] = r_v[4];
        n_v[6] = sm3_pkg::rotl(r_v[5], 19);
        n_v[7] = r_v[6];
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restore) begin
            r_cv <= sm3_pkg::IV;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= r_cv[i] ^ n_v[i];
            end
        end
    end

    // working registers and rotated round constant
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= r_cv;
            r_t <= sm3_pkg::T_LOW;
        end else if (i_ctl.step) begin
            r_v <= n_v;
            r_t <= i_ctl.t_jump ? sm3_pkg::T_HIGH_R16 : sm3_pkg::rotl(r_t, 1);
        end
    end

    assign o_cv = r_cv;

endmodule

// ----- rtl/core/sm3_hash_engine.sv -----
// sm3 hash engine top level: word intake, padding sequencer, digest output
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  request  | i_valid / o_stall  | i_data_word, i_final_word, i_final_bytes
//  digest   | o_valid / i_stall  | o_digest_word, o_digest_index, o_digest_last
//
// a plain word is written straight into the block buffer; the 16th word of a block starts its 64 rounds, one per cycle
// a final word is followed by padding words and 1 or 2 blocks of 64 rounds
// the eight digest words leave at one per cycle while i_stall is low
// o_stall stays high from a final word until its last digest word is taken
// synchronous reset loads the initial chaining value and clears position and count
module sm3_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic        i_final_word,
    input  logic [2:0]  i_final_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    sm3_pkg::t_state    r_state, n_state;
    sm3_pkg::t_state    r_after, n_after;
    logic [3:0]         r_pos, n_pos;
    logic [63:0]        r_byte_cnt, n_byte_cnt;
    logic [5:0]         r_round, n_round;
    logic [2:0]         r_idx, n_idx;
    logic               r_pad_pend, n_pad_pend;
    logic               r_len_hi, n_len_hi;

    logic               in_acc, out_acc, nb4, is_lo;
    logic [2:0]         nb_add;
    logic               buf_wr;
    sm3_pkg::t_word     buf_data;
    sm3_pkg::t_word     w_j, w_j4;
    sm3_pkg::t_word     w_cv [8];
    sm3_pkg::t_rnd_ctl  ctl;

    assign o_stall = (r_state != sm3_pkg::ST_IDLE);
    assign o_valid = (r_state == sm3_pkg::ST_OUT);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign nb4     = i_final_bytes[2];
    assign nb_add  = (!i_final_word || nb4) ? 3'd4 : i_final_bytes;
    assign is_lo   = (r_pos == 4'd15) && r_len_hi && !r_pad_pend;

    // sequencer next state and outputs
    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_pos      = r_pos;
        n_byte_cnt = r_byte_cnt;
        n_round    = r_round;
        n_idx      = r_idx;
        n_pad_pend = r_pad_pend;
        n_len_hi   = r_len_hi;
        buf_wr     = 1'b0;
        buf_data   = '0;
        ctl        = '0;
        ctl.early  = (r_round[5:4] == 2'd0);
        ctl.t_jump = (r_round == 6'd15);
        unique case (r_state)
            sm3_pkg::ST_IDLE: begin
                if (in_acc) begin
                    buf_wr     = 1'b1;
                    buf_data   = (!i_final_word || nb4) ? i_data_word
                               : sm3_pkg::pad_word(i_data_word, i_final_bytes[1:0]);
                    n_byte_cnt = r_byte_cnt + 64'(nb_add);
                    n_pos      = r_pos + 4'd1;
                    n_pad_pend = i_final_word && nb4;
                    n_len_hi   = 1'b0;
                    n_after    = i_final_word ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
                    if (r_pos == 4'd15) begin
                        ctl.load = 1'b1;
                        n_state  = sm3_pkg::ST_COMP;
                    end else begin
                        n_state  = i_final_word ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
                    end
                end
            end
            sm3_pkg::ST_PAD: begin
                buf_wr = 1'b1;
                n_pos  = r_pos + 4'd1;
                if (r_pad_pend) begin
                    buf_data   = sm3_pkg::PAD_WORD;
                    n_pad_pend = 1'b0;
                end else if (r_pos == 4'd14) begin
                    buf_data = r_byte_cnt[60:29];
                    n_len_hi = 1'b1;
                end else if (is_lo) begin
                    buf_data = {r_byte_cnt[28:0], 3'b000};
                end else begin
                    buf_data = '0;
                end
                if (r_pos == 4'd15) begin
                    ctl.load = 1'b1;
                    n_state  = sm3_pkg::ST_COMP;
                    n_after  = is_lo ? sm3_pkg::ST_OUT : sm3_pkg::ST_PAD;
                end
            end
            sm3_pkg::ST_COMP: begin
                ctl.step = 1'b1;
                n_round  = r_round + 6'd1;
                if (r_round == 6'(sm3_pkg::ROUNDS - 1)) begin
                    ctl.fold = 1'b1;
                    n_state  = r_after;
                end
            end
            sm3_pkg::ST_OUT: begin
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        ctl.restore = 1'b1;
                        n_byte_cnt  = '0;
                        n_state     = sm3_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sm3_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sm3_pkg::ST_IDLE;
            r_after    <= sm3_pkg::ST_IDLE;
            r_pos      <= '0;
            r_byte_cnt <= '0;
            r_round    <= '0;
            r_idx      <= '0;
            r_pad_pend <= 1'b0;
            r_len_hi   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_after    <= n_after;
            r_pos      <= n_pos;
            r_byte_cnt <= n_byte_cnt;
            r_round    <= n_round;
            r_idx      <= n_idx;
            r_pad_pend <= n_pad_pend;
            r_len_hi   <= n_len_hi;
        end
    end

    // block buffer and expansion window
    sm3_msg_sched u_sched (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr),
        .i_wr_pos  (r_pos),
        .i_wr_data (buf_data),
        .i_shift   (ctl.step),
        .o_w_j     (w_j),
        .o_w_j4    (w_j4)
    );

    // shared round unit
    sm3_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_w_j   (w_j),
        .i_w_j4  (w_j4),
        .o_cv    (w_cv)
    );

    // digest output
    assign o_digest_word  = w_cv[r_idx];
    assign o_digest_index = r_idx;
    assign o_digest_last  = (r_idx == 3'd7);

endmodule

// ----- rtl/core/sm3_hash_engine_chk.sv -----
// port level checker for the sm3 hash engine, bound to the top level
module sm3_hash_engine_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_digest_word,
    input  logic [2:0]  o_digest_index,
    input  logic        o_digest_last
);

    // no new request while a digest is being delivered
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request accepted during digest output");

    // last flag marks index seven only
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digest_last == (o_digest_index == 3'd7)))
        else $error("digest last flag does not match index");

    // digest words follow back to back in index order
    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_digest_last) |=>
        (o_valid && o_digest_index == $past(o_digest_index) + 3'd1))
        else $error("digest index sequence broken");

    // stalled digest word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_digest_word) && $stable(o_digest_index)))
        else $error("stalled digest word changed");

    // ready for the next message after the last digest word
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_digest_last) |=> (!o_valid && !o_stall))
        else $error("engine not ready after digest");

endmodule

bind sm3_hash_engine sm3_hash_engine_chk u_chk (.*);
